@@ hw/rtl/mqttrx_pkg.sv @@
// Shared types and codes for the MQTT receive deframer.
// Used by the parser, the top level and the port checker; depends on nothing.
package mqttrx_pkg;

    localparam int KIND_W = 3;
    localparam int ERR_W  = 2;
    localparam int LEN_W  = 28;
    localparam int TLEN_W = 16;
    localparam int LIMIT_W = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd512;

    // Byte classes
    localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LENGTH  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TLEN    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TOPIC   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BODY    = 3'd5;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_LEN_FIELD = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LIMIT     = 2'd2;
    localparam logic [ERR_W-1:0] ERR_TOPIC     = 2'd3;

    // Control packet types
    localparam logic [3:0] TYPE_CONNACK = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;

    typedef struct packed {
        logic [KIND_W-1:0] byte_kind;
        logic [3:0]        packet_type;
        logic [LEN_W-1:0]  remaining_length;
        logic [TLEN_W-1:0] topic_length;
        logic              packet_end;
        logic [ERR_W-1:0]  error_code;
        logic              connected;
        logic [7:0]        byte_out;
    } result_t;

endpackage

@@ hw/rtl/mqttrx_parser.sv @@
// Fixed header parser: holds the framing state and classifies one byte.
// Depends on mqttrx_pkg. The result is combinational; the state advances on step.
module mqttrx_parser
    import mqttrx_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic [LIMIT_W-1:0] max_packet_bytes,
    output result_t            result
);

    localparam int CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_TLEN_HI = 3'd2,
        PH_TLEN_LO = 3'd3,
        PH_TOPIC   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_BODY    = 3'd6
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [3:0]         type_reg, type_next;
    logic [LEN_W-1:0]   accum_reg, accum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [TLEN_W-1:0]  tlen_reg, tlen_next;
    logic [TLEN_W-1:0]  topic_left_reg, topic_left_next;
    logic               conn_reg, conn_next;

    logic [KIND_W-1:0]  kind;
    logic               pkt_end;
    logic [ERR_W-1:0]   err;
    logic [4:0]         shift_amt;
    logic [CNT_W-1:0]   count_inc;
    logic [LEN_W-1:0]   accum_sum;
    logic [LEN_W:0]     total;
    logic [LEN_W-1:0]   left_dec;
    logic [TLEN_W-1:0]  tlen_full;

    always_comb begin
        phase_next      = phase_reg;
        type_next       = type_reg;
        accum_next      = accum_reg;
        count_next      = count_reg;
        left_next       = left_reg;
        tlen_next       = tlen_reg;
        topic_left_next = topic_left_reg;
        conn_next       = conn_reg;
        kind            = KIND_HEADER;
        pkt_end         = 1'b0;
        err             = ERR_NONE;

        // The count never passes MAX_LENGTH_BYTES - 1 here, so with the default of 4 the
        // group always lands inside the 28-bit accumulator.
        shift_amt = 5'(count_reg) * 5'd7;
        count_inc = count_reg + 1'b1;
        accum_sum = accum_reg + (LEN_W'(data_byte[6:0]) << shift_amt);
        total     = (LEN_W+1)'(1) + (LEN_W+1)'(count_inc) + (LEN_W+1)'(accum_sum);
        left_dec  = left_reg - 1'b1;
        tlen_full = {tlen_reg[15:8], data_byte};

        case (phase_reg)
            PH_LENGTH: begin
                kind       = KIND_LENGTH;
                accum_next = accum_sum;
                count_next = count_inc;
                if (data_byte[7]) begin
                    if (32'(count_inc) >= MAX_LENGTH_BYTES) begin
                        err        = ERR_LEN_FIELD;
                        phase_next = PH_HEADER;
                    end
                end else begin
                    left_next = accum_sum;
                    if (total > (LEN_W+1)'(max_packet_bytes)) begin
                        err        = ERR_LIMIT;
                        phase_next = PH_HEADER;
                    end else if (type_reg == TYPE_PUBLISH) begin
                        if (accum_sum < LEN_W'(2)) begin
                            err        = ERR_TOPIC;
                            phase_next = PH_HEADER;
                        end else begin
                            phase_next = PH_TLEN_HI;
                        end
                    end else if (accum_sum == '0) begin
                        pkt_end    = 1'b1;
                        phase_next = PH_HEADER;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_TLEN_HI: begin
                kind       = KIND_TLEN;
                tlen_next  = {data_byte, 8'd0};
                left_next  = left_dec;
                phase_next = PH_TLEN_LO;
            end
            PH_TLEN_LO: begin
                kind      = KIND_TLEN;
                tlen_next = tlen_full;
                left_next = left_dec;
                if (LEN_W'(tlen_full) > left_dec) begin
                    err        = ERR_TOPIC;
                    phase_next = PH_HEADER;
                end else begin
                    topic_left_next = tlen_full;
                    if (left_dec == '0) begin
                        pkt_end    = 1'b1;
                        phase_next = PH_HEADER;
                    end else if (tlen_full != '0) begin
                        phase_next = PH_TOPIC;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_TOPIC: begin
                kind            = KIND_TOPIC;
                left_next       = left_dec;
                topic_left_next = topic_left_reg - 1'b1;
                if (left_dec == '0) begin
                    pkt_end    = 1'b1;
                    phase_next = PH_HEADER;
                end else if (topic_left_reg == TLEN_W'(1)) begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD, PH_BODY: begin
                kind      = (phase_reg == PH_PAYLOAD) ? KIND_PAYLOAD : KIND_BODY;
                left_next = left_dec;
                if (left_dec == '0) begin
                    pkt_end    = 1'b1;
                    phase_next = PH_HEADER;
                end
            end
            default: begin
                kind            = KIND_HEADER;
                type_next       = data_byte[7:4];
                accum_next      = '0;
                count_next      = '0;
                left_next       = '0;
                tlen_next       = '0;
                topic_left_next = '0;
                phase_next      = PH_LENGTH;
            end
        endcase

        // A CONNACK counts only when it ends cleanly.
        if (pkt_end && type_reg == TYPE_CONNACK) begin
            conn_next = 1'b1;
        end

        result.byte_kind        = kind;
        result.packet_type      = type_next;
        result.remaining_length = accum_next;
        result.topic_length     = tlen_next;
        result.packet_end       = pkt_end;
        result.error_code       = err;
        result.connected        = conn_next;
        result.byte_out         = data_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            type_reg       <= '0;
            accum_reg      <= '0;
            count_reg      <= '0;
            left_reg       <= '0;
            tlen_reg       <= '0;
            topic_left_reg <= '0;
            conn_reg       <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            type_reg       <= type_next;
            accum_reg      <= accum_next;
            count_reg      <= count_next;
            left_reg       <= left_next;
            tlen_reg       <= tlen_next;
            topic_left_reg <= topic_left_next;
            conn_reg       <= conn_next;
        end
    end

endmodule

@@ hw/rtl/mqtt_receive_packet_deframer.sv @@
// Top level of the MQTT receive deframer: stream ports, limit register, skid buffer.
// Depends on mqttrx_pkg and mqttrx_parser.
//
// Received MQTT bytes enter on the s_ channel, one byte per transfer. Every
// byte gives exactly one result transfer on the m_ channel, in order: the
// byte's class in m_tuser, the packet fields and the byte itself in m_tdata,
// and m_tlast on the byte that ends a packet cleanly.
// The cfg_ channel writes the packet size limit; it is always ready and is
// meant to be written only while no byte is in flight.
// A result is registered in the output register, or in the skid register while
// the output is held. Throughput is one byte per cycle while the receiver keeps
// up: the parser state updates in a single step per byte, and the result register
// plus a one-entry skid register let the input side take one more byte while a
// result waits for m_tready. When the receiver stalls, the skid entry fills and
// s_tready, driven from it, drops; it rises again once the receiver takes a result.
// A synchronous active-low reset returns the parser to expecting a header,
// clears the connected flag, empties both output registers and sets the
// limit to 512 bytes.
module mqtt_receive_packet_deframer
    import mqttrx_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input bytes
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    // Results
    output logic               m_tvalid,
    input  logic               m_tready,
    // [3:0] packet_type, [31:4] remaining_length, [47:32] topic_length,
    // [49:48] error_code, [50] connected, [58:51] byte_out, [63:59] zero
    output logic [63:0]        m_tdata,
    output logic [2:0]         m_tuser,   // [2:0] byte_kind
    output logic               m_tlast,   // packet_end
    // Limit register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data   // max_packet_bytes
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               accept;
    result_t            result;
    result_t            out_reg;
    result_t            skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    mqttrx_parser #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (accept),
        .data_byte        (s_tdata),
        .max_packet_bytes (limit_reg),
        .result           (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    // The skid entry only fills while the output register is held, so
    // s_tready is low whenever the skid entry drains into the output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (accept) begin
                out_reg       <= result;
                out_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            skid_reg       <= result;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.byte_kind;
    assign m_tlast  = out_reg.packet_end;
    assign m_tdata  = {5'd0, out_reg.byte_out, out_reg.connected, out_reg.error_code,
                       out_reg.topic_length, out_reg.remaining_length, out_reg.packet_type};

endmodule

@@ hw/rtl/mqttrx_checker.sv @@
// Port-level checks for the MQTT receive deframer, bound to the top level.
// Depends on mqttrx_pkg; sees only the top-level ports.
module mqttrx_checker
    import mqttrx_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result must hold until the receiver takes it.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // A packet that ends carries no error.
    a_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[49:48] == ERR_NONE)
        else $error("packet end together with an error");

    // Errors are raised only on length or topic length bytes.
    a_err_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[49:48] != ERR_NONE |-> m_tuser == KIND_LENGTH
            || m_tuser == KIND_TLEN)
        else $error("error on a byte of the wrong class");

    // A header byte starts with cleared lengths.
    a_header_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_HEADER |-> m_tdata[47:4] == '0 && !m_tlast)
        else $error("header byte with stale lengths");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mqtt_receive_packet_deframer mqttrx_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ verif/mqtt_rx_checker.sv @@
// Result checker for the MQTT receive deframer: keeps its own copy of the parser
// state, predicts one result per input byte and compares the m_ channel transfers.
// Depends on mqttrx_pkg for the result layout, byte classes and error codes.
module mqtt_rx_checker
    import mqttrx_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [63:0]        m_tdata,
    input  logic [2:0]         m_tuser,
    input  logic               m_tlast,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam int LENGTH_BYTES_MAX = 4;

    typedef enum logic [2:0] {
        AWAIT_HEADER,
        IN_LENGTH,
        TLEN_HIGH,
        TLEN_LOW,
        IN_TOPIC,
        IN_PAYLOAD,
        IN_BODY
    } phase_t;

    phase_t             phase;
    logic [3:0]         cur_type;
    logic [LEN_W-1:0]   len_acc;
    logic [2:0]         len_count;
    logic [LEN_W-1:0]   body_left;
    logic [TLEN_W-1:0]  tlen_val;
    logic [TLEN_W-1:0]  topic_left;
    logic               conn;
    logic [LIMIT_W-1:0] limit;
    result_t            expected_q[$];
    int                 mismatches = 0;

    // Advances the parser copy by one byte and returns the result it should give.
    function automatic result_t frame_byte(input logic [7:0] b);
        result_t     r;
        logic        ends;
        int unsigned total;
        r = '0;
        ends = 1'b0;
        r.byte_out = b;
        case (phase)
            IN_LENGTH: begin
                r.byte_kind = KIND_LENGTH;
                if (len_count < 4)
                    len_acc = len_acc + (LEN_W'(b[6:0]) << (7 * len_count));
                len_count = len_count + 3'd1;
                if (b[7]) begin
                    if (len_count >= LENGTH_BYTES_MAX) begin
                        r.error_code = ERR_LEN_FIELD;
                        phase = AWAIT_HEADER;
                    end
                end else begin
                    total = 1 + len_count + len_acc;
                    body_left = len_acc;
                    if (total > limit) begin
                        r.error_code = ERR_LIMIT;
                        phase = AWAIT_HEADER;
                    end else if (cur_type == TYPE_PUBLISH) begin
                        // A PUBLISH body must at least hold the topic length.
                        if (len_acc < 2) begin
                            r.error_code = ERR_TOPIC;
                            phase = AWAIT_HEADER;
                        end else begin
                            phase = TLEN_HIGH;
                        end
                    end else if (len_acc == 0) begin
                        ends = 1'b1;
                    end else begin
                        phase = IN_BODY;
                    end
                end
            end
            TLEN_HIGH: begin
                r.byte_kind = KIND_TLEN;
                tlen_val = {b, 8'h00};
                body_left = body_left - 1'b1;
                phase = TLEN_LOW;
            end
            TLEN_LOW: begin
                r.byte_kind = KIND_TLEN;
                tlen_val = tlen_val | b;
                body_left = body_left - 1'b1;
                if (tlen_val > body_left) begin
                    r.error_code = ERR_TOPIC;
                    phase = AWAIT_HEADER;
                end else begin
                    topic_left = tlen_val;
                    if (body_left == 0)
                        ends = 1'b1;
                    else
                        phase = (topic_left != 0) ? IN_TOPIC : IN_PAYLOAD;
                end
            end
            IN_TOPIC: begin
                r.byte_kind = KIND_TOPIC;
                body_left = body_left - 1'b1;
                topic_left = topic_left - 1'b1;
                if (body_left == 0)
                    ends = 1'b1;
                else if (topic_left == 0)
                    phase = IN_PAYLOAD;
            end
            IN_PAYLOAD, IN_BODY: begin
                r.byte_kind = (phase == IN_PAYLOAD) ? KIND_PAYLOAD : KIND_BODY;
                body_left = body_left - 1'b1;
                if (body_left == 0)
                    ends = 1'b1;
            end
            default: begin
                r.byte_kind = KIND_HEADER;
                cur_type = b[7:4];
                len_acc = '0;
                len_count = '0;
                body_left = '0;
                tlen_val = '0;
                topic_left = '0;
                phase = IN_LENGTH;
            end
        endcase
        if (ends) begin
            r.packet_end = 1'b1;
            phase = AWAIT_HEADER;
            if (cur_type == TYPE_CONNACK)
                conn = 1'b1;
        end
        r.packet_type = cur_type;
        r.remaining_length = len_acc;
        r.topic_length = tlen_val;
        r.connected = conn;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        logic    bad;
        if (!aresetn) begin
            phase = AWAIT_HEADER;
            cur_type = '0;
            len_acc = '0;
            len_count = '0;
            body_left = '0;
            tlen_val = '0;
            topic_left = '0;
            conn = 1'b0;
            limit = LIMIT_RESET;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.byte_kind = m_tuser;
                got.packet_type = m_tdata[3:0];
                got.remaining_length = m_tdata[31:4];
                got.topic_length = m_tdata[47:32];
                got.error_code = m_tdata[49:48];
                got.connected = m_tdata[50];
                got.byte_out = m_tdata[58:51];
                got.packet_end = m_tlast;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with no byte waiting, byte %02h",
                                 $time, got.byte_out);
                end else begin
                    want = expected_q.pop_front();
                    bad = got.byte_kind != want.byte_kind
                       || got.packet_type != want.packet_type
                       || got.remaining_length != want.remaining_length
                       || got.topic_length != want.topic_length
                       || got.packet_end != want.packet_end
                       || got.error_code != want.error_code
                       || got.connected != want.connected
                       || got.byte_out != want.byte_out
                       || m_tdata[63:59] != 5'd0;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("%0t: expected kind %0d type %0d len %0d topic %0d ",
                                   $time, want.byte_kind, want.packet_type,
                                   want.remaining_length, want.topic_length);
                            $display("end %0b err %0d conn %0b byte %02h pad 0",
                                     want.packet_end, want.error_code, want.connected,
                                     want.byte_out);
                            $write("%0t: actual   kind %0d type %0d len %0d topic %0d ",
                                   $time, got.byte_kind, got.packet_type,
                                   got.remaining_length, got.topic_length);
                            $display("end %0b err %0d conn %0b byte %02h pad %0h",
                                     got.packet_end, got.error_code, got.connected,
                                     got.byte_out, m_tdata[63:59]);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                limit = cfg_data;
            // The result of a byte accepted at this edge cannot appear before the next one.
            if (s_tvalid && s_tready)
                expected_q.push_back(frame_byte(s_tdata));
        end
        fail_count <= mismatches;
        pending <= expected_q.size();
    end

endmodule

@@ verif/tb_mqtt_receive_packet_deframer.sv @@
// Testbench top for the MQTT receive deframer: clock, reset, byte stimulus,
// receiver back-pressure and the verdict. Depends on mqttrx_pkg, the block
// and mqtt_rx_checker, which predicts and compares every result.
module tb_mqtt_receive_packet_deframer;
    import mqttrx_pkg::*;

    localparam logic [3:0] TYPE_CONNECT    = 4'd1;
    localparam logic [3:0] TYPE_PINGREQ    = 4'd12;
    localparam logic [3:0] TYPE_DISCONNECT = 4'd14;
    localparam int LEN_FIELD_MAX    = 4;
    localparam int PHASE_BYTES      = 280;
    localparam int CALM_BYTES       = 150;
    localparam int HOLD_OFF_CYCLES  = 200;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [63:0]        m_tdata;
    logic [2:0]         m_tuser;
    logic               m_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;
    int                 fail_count;
    int                 pending;

    logic               calm = 1'b0;
    logic               hold_off_req = 1'b0;
    logic [LIMIT_W-1:0] cur_limit = LIMIT_RESET;
    int                 bytes_sent = 0;

    mqtt_receive_packet_deframer DUT (.*);

    mqtt_rx_checker checker_inst (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request, no random stalls while calm.
    initial begin
        logic hold_off_done;
        hold_off_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_done = 1'b1;
            end
            m_tready <= calm || ($urandom_range(99) >= 34);
        end
    end

    function automatic int len_width(input int v);
        return v < 128 ? 1 : v < 16384 ? 2 : v < 2097152 ? 3 : 4;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_limit = v;
    endtask

    // Stops offering bytes and waits until every result has been taken or the wait limit is reached.
    task automatic settle();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
            n++;
        end while (pending != 0 && n < 5000);
        repeat (3) @(posedge aclk);
    endtask

    // Sends a packet; it stops where the parser is known to flag an error,
    // so that the next packet starts on a header.
    task automatic send_packet(input logic [7:0] header, input int rlen, input int tlen,
                               input int width);
        send_byte(header);
        for (int i = 0; i < width; i++)
            send_byte({i < width - 1, 7'(rlen >> (7 * i))});
        if (1 + width + rlen > cur_limit)
            return;
        if (header[7:4] == TYPE_PUBLISH) begin
            if (rlen < 2)
                return;
            send_byte(8'(tlen >> 8));
            send_byte(8'(tlen));
            if (tlen > rlen - 2)
                return;
            rlen = rlen - 2;
        end
        repeat (rlen) send_byte(8'($urandom_range(255)));
    endtask

    task automatic random_packet();
        int         pick;
        int         rlen;
        int         tlen;
        int         width;
        int         target;
        logic [3:0] ptype;
        pick = $urandom_range(99);
        if (pick < 4) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
            return;
        end
        if (pick < 7) begin
            // Continuation bit still set on the last allowed length byte.
            send_byte(8'($urandom_range(255)));
            repeat (LEN_FIELD_MAX) send_byte({1'b1, 7'($urandom_range(127))});
            return;
        end
        pick = $urandom_range(99);
        ptype = pick < 40 ? TYPE_PUBLISH : pick < 50 ? TYPE_CONNACK : 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 70) begin
            rlen = $urandom_range(24);
        end else if (pick < 85) begin
            rlen = $urandom_range(300, 25);
        end else if (pick < 93 && cur_limit <= 400) begin
            // Whole packet aimed at the limit or one byte above it.
            target = int'(cur_limit) + $urandom_range(1);
            rlen = target - 1 - len_width(target - 2);
            if (rlen < 0)
                rlen = 0;
        end else begin
            rlen = $urandom_range(28'hFFFFFFF, 65536);
        end
        width = len_width(rlen);
        if ($urandom_range(99) < 15)
            width = $urandom_range(LEN_FIELD_MAX, width);
        pick = $urandom_range(99);
        if (rlen < 2 || pick < 15)
            tlen = $urandom_range(16'hFFFF);
        else if (pick < 30)
            tlen = rlen - 2;
        else if (pick < 40)
            tlen = 0;
        else
            tlen = $urandom_range(rlen - 2);
        send_packet({ptype, 4'($urandom_range(15))}, rlen, tlen, width);
    endtask

    initial begin
        logic [7:0]         opening [$];
        logic [LIMIT_W-1:0] limits [6];
        int                 phase_end;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        opening = '{{TYPE_CONNACK, 4'h0}, 8'h02, 8'h00, 8'h00,
                    {TYPE_PUBLISH, 4'h1}, 8'h04, 8'h00, 8'h01, 8'h54, 8'h50,
                    {TYPE_PINGREQ, 4'h0}, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    {TYPE_CONNECT, 4'h0}, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                    {TYPE_PUBLISH, 4'hF}, 8'h01,
                    {TYPE_PUBLISH, 4'h0}, 8'h03, 8'hFF, 8'hFF,
                    {TYPE_DISCONNECT, 4'h0}, 8'h00};
        foreach (opening[i])
            send_byte(opening[i]);

        limits = '{16'd0, 16'd2, 16'hFFFF, 16'($urandom_range(300, 3)),
                   16'($urandom_range(65534, 301)), LIMIT_RESET};
        foreach (limits[p]) begin
            settle();
            write_limit(limits[p]);
            phase_end = bytes_sent + PHASE_BYTES;
            if (p == 3) begin
                calm = 1'b1;
                hold_off_req = 1'b1;
            end
            while (bytes_sent < phase_end) begin
                if (bytes_sent >= phase_end - PHASE_BYTES + CALM_BYTES)
                    calm = 1'b0;
                random_packet();
            end
            calm = 1'b0;
        end
        settle();

        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
